// ----- rtl/core/pmblc_pkg.sv -----
// ----------------------------------------------------------------------------
// pmblc_pkg
// Shared codes, widths and types of the power mode button LED controller.
// ----------------------------------------------------------------------------
package pmblc_pkg;

  localparam int IDLE_W = 20;
  localparam int HOLD_W = 16;
  localparam int TICK_W = 16;

  // Power and mode states
  localparam logic [3:0] ST_ADV   = 4'd0;
  localparam logic [3:0] ST_CONN  = 4'd1;
  localparam logic [3:0] ST_P1    = 4'd2;
  localparam logic [3:0] ST_P2    = 4'd3;
  localparam logic [3:0] ST_P3    = 4'd4;
  localparam logic [3:0] ST_START = 4'd5;
  localparam logic [3:0] ST_CHG   = 4'd6;
  localparam logic [3:0] ST_FULL  = 4'd7;
  localparam logic [3:0] ST_STOP  = 4'd8;
  localparam logic [3:0] ST_DOWN  = 4'd9;

  // LED colors, bit 0 red, bit 1 green, bit 2 blue
  localparam logic [2:0] LED_OFF    = 3'd0;
  localparam logic [2:0] LED_GREEN  = 3'd2;
  localparam logic [2:0] LED_YELLOW = 3'd3;
  localparam logic [2:0] LED_BLUE   = 3'd4;

  // Charger status
  localparam logic [1:0] CHG_NOT  = 2'd0;
  localparam logic [1:0] CHG_ON   = 2'd1;
  localparam logic [1:0] CHG_FULL = 2'd2;
  localparam logic [2:0] CHARGER_FULL_CODE = 3'd6;

  // Button events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Charger notifications
  localparam logic [1:0] NOTIFY_NONE  = 2'd0;
  localparam logic [1:0] NOTIFY_START = 2'd1;
  localparam logic [1:0] NOTIFY_END   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_HOLD         = 2'd1;
  localparam logic [1:0] CFG_CONN_LED     = 2'd2;

  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 20'd20000;
  localparam logic [HOLD_W-1:0] HOLD_RST         = 16'd100;
  localparam logic [TICK_W-1:0] CONN_LED_RST     = 16'd600;

  localparam logic [6:0] BLINK_PERIOD = 7'd120;

  typedef struct packed {
    logic [1:0] ev;
    logic       set_blue;
    logic       armed;
  } btn_evt_t;

  typedef struct packed {
    logic [3:0] cur_state;
    logic [3:0] next_state;
    logic       tick_clear;
    logic [1:0] preset;
    logic       stop;
    logic       drop;
    logic       sadv;
    logic [1:0] notify;
    logic       hib;
  } fsm_out_t;

endpackage

// ----- rtl/core/pmblc_button.sv -----
// ----------------------------------------------------------------------------
// pmblc_button
// Power button qualifier: short press and long hold detection.
// ----------------------------------------------------------------------------
module pmblc_button (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           level,
  input  logic [pmblc_pkg::HOLD_W-1:0]   hold_ticks,
  output pmblc_pkg::btn_evt_t            evt
);
  import pmblc_pkg::*;

  logic              ignore_r, ignore_nxt;
  logic              was_down_r, was_down_nxt;
  logic              armed_r, armed_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [HOLD_W-1:0] hold_inc;

  always_comb begin
    ignore_nxt   = ignore_r;
    was_down_nxt = was_down_r;
    armed_nxt    = armed_r;
    hold_nxt     = hold_r;
    evt.ev       = EV_NONE;
    evt.set_blue = 1'b0;
    hold_inc     = (hold_r == '1) ? hold_r : HOLD_W'(hold_r + 1'b1);
    if (ignore_r) begin
      if (level) begin
        ignore_nxt = 1'b0;
      end
    end else if (!level) begin
      was_down_nxt = 1'b1;
      hold_nxt     = hold_inc;
      if (hold_inc >= hold_ticks) begin
        armed_nxt    = 1'b1;
        evt.set_blue = 1'b1;
      end
    end else if (was_down_r) begin
      if (armed_r) begin
        evt.ev = EV_LONG;
      end else if (hold_r != '0 && hold_r < hold_ticks) begin
        evt.ev = EV_SHORT;
      end
      hold_nxt  = '0;
      armed_nxt = 1'b0;
    end else begin
      was_down_nxt = 1'b0;
    end
    evt.armed = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_r   <= 1'b1;
      was_down_r <= 1'b0;
      armed_r    <= 1'b0;
      hold_r     <= '0;
    end else if (accept) begin
      ignore_r   <= ignore_nxt;
      was_down_r <= was_down_nxt;
      armed_r    <= armed_nxt;
      hold_r     <= hold_nxt;
    end
  end

endmodule

// ----- rtl/core/pmblc_fsm.sv -----
// ----------------------------------------------------------------------------
// pmblc_fsm
// Power and mode state machine with charger decode and idle countdown.
// ----------------------------------------------------------------------------
module pmblc_fsm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           charge_pin,
  input  logic [2:0]                     charger_bits,
  input  logic                           link_active,
  input  logic                           adv_stopped,
  input  logic [1:0]                     ev,
  input  logic [pmblc_pkg::IDLE_W-1:0]   idle_timeout_ticks,
  output pmblc_pkg::fsm_out_t            fo
);
  import pmblc_pkg::*;

  logic [3:0]        state_r, state_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic [1:0]        chg;

  always_comb begin
    if (charger_bits == CHARGER_FULL_CODE) begin
      chg = CHG_FULL;
    end else if (!charge_pin) begin
      chg = CHG_ON;
    end else begin
      chg = CHG_NOT;
    end

    idle_nxt = (idle_r != '0) ? IDLE_W'(idle_r - 1'b1) : idle_r;
    if (state_r != ST_ADV && state_r <= ST_STOP) begin
      idle_nxt = idle_timeout_ticks;
    end

    state_nxt     = state_r;
    fo.tick_clear = 1'b0;
    fo.preset     = 2'd0;
    fo.stop       = 1'b0;
    fo.drop       = 1'b0;
    fo.sadv       = 1'b0;
    fo.notify     = NOTIFY_NONE;
    fo.hib        = 1'b0;

    case (state_r)
      ST_CONN: begin
        if (chg == CHG_ON) begin
          fo.tick_clear = 1'b1;
          state_nxt     = ST_START;
        end else begin
          if (!link_active) begin
            fo.tick_clear = 1'b1;
            state_nxt     = ST_ADV;
          end
          if (ev == EV_LONG) begin
            state_nxt = ST_DOWN;
          end
        end
      end
      ST_P1, ST_P2, ST_P3: begin
        if (chg == CHG_ON) begin
          fo.tick_clear = 1'b1;
          state_nxt     = ST_START;
        end else if (ev == EV_SHORT) begin
          fo.tick_clear = 1'b1;
          if (state_r == ST_P3) begin
            fo.stop   = 1'b1;
            state_nxt = ST_ADV;
          end else begin
            // Preset strobe carries the low bits of the current state code
            fo.preset = state_r[1:0];
            state_nxt = 4'(state_r + 1'b1);
          end
        end else if (ev == EV_LONG) begin
          state_nxt = ST_DOWN;
        end
      end
      ST_START: begin
        fo.stop   = 1'b1;
        fo.drop   = 1'b1;
        fo.notify = NOTIFY_START;
        state_nxt = ST_CHG;
      end
      ST_CHG: begin
        if (chg == CHG_NOT) begin
          state_nxt = ST_STOP;
        end else if (chg == CHG_FULL) begin
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        if (chg == CHG_NOT) begin
          state_nxt = ST_STOP;
        end
      end
      ST_STOP: begin
        fo.sadv   = adv_stopped;
        fo.notify = NOTIFY_END;
        state_nxt = ST_ADV;
      end
      ST_DOWN: begin
        fo.stop   = 1'b1;
        fo.hib    = 1'b1;
        idle_nxt  = idle_timeout_ticks;
        state_nxt = ST_ADV;
      end
      default: begin
        if (idle_nxt == '0) begin
          state_nxt = ST_DOWN;
        end else if (chg == CHG_ON) begin
          fo.tick_clear = 1'b1;
          state_nxt     = ST_START;
        end else if (link_active) begin
          fo.tick_clear = 1'b1;
          state_nxt     = ST_CONN;
        end else if (ev == EV_SHORT) begin
          fo.tick_clear = 1'b1;
          state_nxt     = ST_P1;
          fo.preset     = 2'd1;
        end else if (ev == EV_LONG) begin
          state_nxt = ST_DOWN;
        end
      end
    endcase
    fo.cur_state  = state_r;
    fo.next_state = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ADV;
      idle_r  <= IDLE_TIMEOUT_RST;
    end else if (accept) begin
      state_r <= state_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

// ----- rtl/core/pmblc_led.sv -----
// ----------------------------------------------------------------------------
// pmblc_led
// RGB LED pattern generator: per-state blink and the connected indication.
// ----------------------------------------------------------------------------
module pmblc_led (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [3:0]                     state,
  input  logic                           tick_clear,
  input  logic                           set_blue,
  input  logic [pmblc_pkg::TICK_W-1:0]   connected_led_ticks,
  output logic [2:0]                     color
);
  import pmblc_pkg::*;

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [2:0]        color_r;
  logic              done_r, done_nxt;
  logic [TICK_W-1:0] tick_base, t_conn;
  logic [6:0]        t_blink;
  logic [2:0]        color_base;

  // Lit for the first 6 of every 12 ticks, over the first n slots of a period
  function automatic logic blink_on(input logic [6:0] t, input logic [1:0] n);
    logic on;
    on = (t < 7'd6) ||
         (n >= 2'd2 && t >= 7'd12 && t < 7'd18) ||
         (n == 2'd3 && t >= 7'd24 && t < 7'd30);
    return on;
  endfunction

  always_comb begin
    color_base = set_blue ? LED_BLUE : color_r;
    tick_base  = tick_clear ? '0 : tick_r;
    t_blink    = (tick_base >= TICK_W'(BLINK_PERIOD)) ? 7'd0 : tick_base[6:0];
    t_conn     = (tick_base > connected_led_ticks) ? '0 : tick_base;
    color      = color_base;
    tick_nxt   = tick_base;
    done_nxt   = done_r;
    case (state)
      ST_CONN: begin
        tick_nxt = t_conn;
        if (!done_r) begin
          if (t_conn >= connected_led_ticks) begin
            color    = LED_OFF;
            done_nxt = 1'b1;
          end else begin
            color    = LED_BLUE;
            tick_nxt = TICK_W'(t_conn + 1'b1);
          end
        end
      end
      ST_P1, ST_P2, ST_P3: begin
        color    = blink_on(t_blink, 2'(state - ST_P1 + 1'b1)) ? LED_YELLOW : LED_OFF;
        tick_nxt = TICK_W'(t_blink + 1'b1);
      end
      ST_CHG: begin
        color    = blink_on(t_blink, 2'd1) ? LED_GREEN : LED_OFF;
        tick_nxt = TICK_W'(t_blink + 1'b1);
      end
      ST_FULL: begin
        color = LED_GREEN;
      end
      ST_DOWN: begin
        color = LED_OFF;
      end
      default: begin
        color    = blink_on(t_blink, 2'd1) ? LED_BLUE : LED_OFF;
        tick_nxt = TICK_W'(t_blink + 1'b1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      color_r <= LED_OFF;
      done_r  <= 1'b0;
    end else if (accept) begin
      tick_r  <= tick_nxt;
      color_r <= color;
      done_r  <= done_nxt;
    end
  end

endmodule

// ----- rtl/core/power_mode_button_led_controller_core.sv -----
// ----------------------------------------------------------------------------
// power_mode_button_led_controller_core
// Power button, charger and idle-timeout mode controller with RGB LED drive.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item per task tick on the in_ stream: button level, charge pin,
//   charger status bits, link flag and advertising-stopped flag. Each item
//   yields exactly one result on the out_ stream: the new mode state, the LED
//   drive, the action strobes (preset load, stimulus stop, link drop,
//   advertising restart, charger notification, hibernate) and the armed flag.
//   The result is valid in the cycle after input transfer; throughput is one
//   item per cycle unless the receiver stalls, set by the single result
//   register behind the state logic. The input side stays ready while the
//   result register is empty or is being drained in the same cycle, so a
//   stalled receiver holds the pending result and stops input after one item.
//   Reset (rst_n low, synchronous) returns to advertising, reloads the idle
//   countdown to 20000, loads the register defaults (idle 20000, hold 100,
//   connected LED 600), turns the LED off and ignores the button until the
//   first released tick. Write cfg_ registers only while the block is idle;
//   the cfg_ channel is always ready and indexes above 2 are dropped.
// ----------------------------------------------------------------------------
module power_mode_button_led_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] button_level, [1] charge_pin, [4:2] charger_bits, [5] link_active,
  // [6] adv_stopped, [7] zero
  input  logic [7:0]  in_tdata,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] mode_state, [4] led_red, [5] led_green, [6] led_blue,
  // [8:7] load_preset, [9] stop_stimuli, [10] drop_link, [11] start_adv,
  // [13:12] notify_code, [14] enter_hibernate, [15] shutdown_armed
  output logic [15:0] out_tdata,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import pmblc_pkg::*;

  logic              in_fire;
  logic              out_tvalid_r;
  logic [15:0]       out_tdata_r;
  logic [IDLE_W-1:0] idle_timeout_r;
  logic [HOLD_W-1:0] hold_ticks_r;
  logic [TICK_W-1:0] conn_led_r;
  btn_evt_t          btn;
  fsm_out_t          fo;
  logic [2:0]        led_color;

  // Accept while the result register is free or drains this cycle
  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      hold_ticks_r   <= HOLD_RST;
      conn_led_r     <= CONN_LED_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        CFG_HOLD:         hold_ticks_r   <= cfg_data[HOLD_W-1:0];
        CFG_CONN_LED:     conn_led_r     <= cfg_data[TICK_W-1:0];
        default: begin
          // Drop writes outside the register list
        end
      endcase
    end
  end

  // Qualify the button first: its event steers the state machine
  pmblc_button u_button (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_fire),
    .level      (in_tdata[0]),
    .hold_ticks (hold_ticks_r),
    .evt        (btn)
  );

  pmblc_fsm u_fsm (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (in_fire),
    .charge_pin         (in_tdata[1]),
    .charger_bits       (in_tdata[4:2]),
    .link_active        (in_tdata[5]),
    .adv_stopped        (in_tdata[6]),
    .ev                 (btn.ev),
    .idle_timeout_ticks (idle_timeout_r),
    .fo                 (fo)
  );

  // LED pattern follows the state after the transition
  pmblc_led u_led (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (in_fire),
    .state               (fo.next_state),
    .tick_clear          (fo.tick_clear),
    .set_blue            (btn.set_blue),
    .connected_led_ticks (conn_led_r),
    .color               (led_color)
  );

  // Result register: load on input transfer, release on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {btn.armed, fo.hib, fo.notify, fo.sadv, fo.drop, fo.stop,
                      fo.preset, led_color, fo.next_state};
    end
  end

`ifndef ASSERT_OFF
  // A hibernate strobe always comes with stimulus stop and a return to advertising
  a_hib_returns_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[14]) |-> (out_tdata[3:0] == ST_ADV && out_tdata[9]))
    else $error("hibernate strobe without advertising state or stimulus stop");

  // Start charging always advances to charging with the start notification
  a_start_to_chg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && fo.cur_state == ST_START) |=>
      (out_tdata[3:0] == ST_CHG && out_tdata[13:12] == NOTIFY_START))
    else $error("start charging did not advance to charging");

  // Never overwrite a result that the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && out_tvalid_r && !out_tready))
    else $error("result register overwritten while stalled");
`endif

endmodule

// ----- bench/mode_result_checker.sv -----
// ----------------------------------------------------------------------------
// mode_result_checker
// Watches the tick, result and register channels of the power mode controller,
// predicts each result from its own copy of the controller state and compares.
// ----------------------------------------------------------------------------
module mode_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          open_results,
  output int          fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import pmblc_pkg::*;

  localparam int unsigned BLINK_SLOT = 12;
  localparam int unsigned BLINK_ON   = 6;

  // Field order follows out_tdata from the top bit down
  typedef struct packed {
    logic       shutdown_armed;
    logic       enter_hibernate;
    logic [1:0] notify_code;
    logic       start_adv;
    logic       drop_link;
    logic       stop_stimuli;
    logic [1:0] load_preset;
    logic       led_blue;
    logic       led_green;
    logic       led_red;
    logic [3:0] mode_state;
  } mode_result_t;

  // Register copies
  logic [IDLE_W-1:0] idle_limit;
  logic [HOLD_W-1:0] hold_limit;
  logic [TICK_W-1:0] conn_led_len;

  // Controller state copy
  logic [3:0]        mode;
  logic [IDLE_W-1:0] idle_left;
  logic [HOLD_W-1:0] held_ticks;
  logic              wait_release;
  logic              was_pressed;
  logic              armed;
  logic [TICK_W-1:0] led_phase;
  logic              conn_led_spent;
  logic [2:0]        led_rgb;

  mode_result_t mode_results_due[$];
  mode_result_t due, got;
  string        bad_fields;

  initial fail_count = 0;

  function automatic mode_result_t step_controller(input logic [7:0] d);
    logic        btn, pin, link, advstop;
    logic [2:0]  bits;
    logic [1:0]  chg, ev;
    logic [3:0]  s;
    logic [2:0]  blink_rgb;
    int unsigned blinks;
    mode_result_t r;
    btn     = d[0];
    pin     = d[1];
    bits    = d[4:2];
    link    = d[5];
    advstop = d[6];
    r       = '0;
    ev      = EV_NONE;

    if (bits == CHARGER_FULL_CODE) chg = CHG_FULL;
    else if (!pin)                 chg = CHG_ON;
    else                           chg = CHG_NOT;

    // Button qualification; the pressed flag stays set once seen
    if (wait_release) begin
      if (btn) wait_release = 1'b0;
    end else if (!btn) begin
      was_pressed = 1'b1;
      if (held_ticks != '1) held_ticks = held_ticks + 1'b1;
      if (held_ticks >= hold_limit) begin
        armed   = 1'b1;
        led_rgb = LED_BLUE;
      end
    end else if (was_pressed) begin
      if (armed) ev = EV_LONG;
      else if (held_ticks != 0 && held_ticks < hold_limit) ev = EV_SHORT;
      held_ticks = '0;
      armed      = 1'b0;
    end

    if (idle_left != 0) idle_left = idle_left - 1'b1;
    s = mode;
    if (s != ST_ADV && s <= ST_STOP) idle_left = idle_limit;

    case (s)
      ST_CONN: begin
        if (chg == CHG_ON) begin
          led_phase = '0;
          s = ST_START;
        end else begin
          if (!link) begin
            led_phase = '0;
            s = ST_ADV;
          end
          if (ev == EV_LONG) s = ST_DOWN;
        end
      end
      ST_P1, ST_P2, ST_P3: begin
        if (chg == CHG_ON) begin
          led_phase = '0;
          s = ST_START;
        end else if (ev == EV_SHORT) begin
          led_phase = '0;
          if (s == ST_P3) begin
            r.stop_stimuli = 1'b1;
            s = ST_ADV;
          end else begin
            r.load_preset = s[1:0];
            s = s + 1'b1;
          end
        end else if (ev == EV_LONG) begin
          s = ST_DOWN;
        end
      end
      ST_START: begin
        r.stop_stimuli = 1'b1;
        r.drop_link    = 1'b1;
        r.notify_code  = NOTIFY_START;
        s = ST_CHG;
      end
      ST_CHG: begin
        if (chg == CHG_NOT)       s = ST_STOP;
        else if (chg == CHG_FULL) s = ST_FULL;
      end
      ST_FULL: begin
        if (chg == CHG_NOT) s = ST_STOP;
      end
      ST_STOP: begin
        r.start_adv   = advstop;
        r.notify_code = NOTIFY_END;
        s = ST_ADV;
      end
      ST_DOWN: begin
        r.stop_stimuli    = 1'b1;
        r.enter_hibernate = 1'b1;
        led_rgb   = LED_OFF;
        idle_left = idle_limit;
        s = ST_ADV;
      end
      default: begin
        if (idle_left == 0) begin
          s = ST_DOWN;
        end else if (chg == CHG_ON) begin
          led_phase = '0;
          s = ST_START;
        end else if (link) begin
          led_phase = '0;
          s = ST_CONN;
        end else if (ev == EV_SHORT) begin
          led_phase = '0;
          s = ST_P1;
          r.load_preset = 2'd1;
        end else if (ev == EV_LONG) begin
          s = ST_DOWN;
        end
      end
    endcase
    mode = s;

    // LED pattern of the new state
    case (mode)
      ST_CONN: begin
        if (led_phase > conn_led_len) led_phase = '0;
        if (!conn_led_spent) begin
          if (led_phase >= conn_led_len) begin
            led_rgb        = LED_OFF;
            conn_led_spent = 1'b1;
          end else begin
            led_rgb   = LED_BLUE;
            led_phase = led_phase + 1'b1;
          end
        end
      end
      ST_FULL: led_rgb = LED_GREEN;
      ST_DOWN: led_rgb = LED_OFF;
      default: begin
        blinks    = 1;
        blink_rgb = LED_BLUE;
        if (mode == ST_P1 || mode == ST_P2 || mode == ST_P3) begin
          blink_rgb = LED_YELLOW;
          blinks    = mode - ST_P1 + 1;
        end else if (mode == ST_CHG) begin
          blink_rgb = LED_GREEN;
        end
        if (led_phase >= BLINK_PERIOD) led_phase = '0;
        if (led_phase < BLINK_SLOT * blinks && led_phase % BLINK_SLOT < BLINK_ON)
          led_rgb = blink_rgb;
        else
          led_rgb = LED_OFF;
        led_phase = led_phase + 1'b1;
      end
    endcase

    r.mode_state     = mode;
    r.led_red        = led_rgb[0];
    r.led_green      = led_rgb[1];
    r.led_blue       = led_rgb[2];
    r.shutdown_armed = armed;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_limit     = IDLE_TIMEOUT_RST;
      hold_limit     = HOLD_RST;
      conn_led_len   = CONN_LED_RST;
      mode           = ST_ADV;
      idle_left      = IDLE_TIMEOUT_RST;
      held_ticks     = '0;
      wait_release   = 1'b1;
      was_pressed    = 1'b0;
      armed          = 1'b0;
      led_phase      = '0;
      conn_led_spent = 1'b0;
      led_rgb        = LED_OFF;
      mode_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDLE_TIMEOUT: idle_limit   = cfg_data;
          CFG_HOLD:         hold_limit   = cfg_data[HOLD_W-1:0];
          CFG_CONN_LED:     conn_led_len = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) mode_results_due.push_back(step_controller(in_tdata));
      if (out_tvalid && out_tready) begin
        got = mode_result_t'(out_tdata);
        if (mode_results_due.size() == 0) begin
          if (fail_count < 10) $display("%0t: result %h arrived with none pending", $realtime,
                                        out_tdata);
          fail_count++;
        end else begin
          due = mode_results_due.pop_front();
          bad_fields = "";
          if (got.mode_state !== due.mode_state)         bad_fields = {bad_fields, " mode_state"};
          if (got.led_red !== due.led_red)               bad_fields = {bad_fields, " led_red"};
          if (got.led_green !== due.led_green)           bad_fields = {bad_fields, " led_green"};
          if (got.led_blue !== due.led_blue)             bad_fields = {bad_fields, " led_blue"};
          if (got.load_preset !== due.load_preset)       bad_fields = {bad_fields, " load_preset"};
          if (got.stop_stimuli !== due.stop_stimuli)     bad_fields = {bad_fields, " stop_stimuli"};
          if (got.drop_link !== due.drop_link)           bad_fields = {bad_fields, " drop_link"};
          if (got.start_adv !== due.start_adv)           bad_fields = {bad_fields, " start_adv"};
          if (got.notify_code !== due.notify_code)       bad_fields = {bad_fields, " notify_code"};
          if (got.enter_hibernate !== due.enter_hibernate)
            bad_fields = {bad_fields, " enter_hibernate"};
          if (got.shutdown_armed !== due.shutdown_armed) bad_fields = {bad_fields, " shutdown_armed"};
          if (bad_fields != "") begin
            if (fail_count < 10)
              $display("%0t: result mismatch in%s: expected %h, got %h", $realtime, bad_fields,
                       due, got);
            fail_count++;
          end
        end
      end
    end
    open_results <= mode_results_due.size();
  end

endmodule

// ----- bench/power_mode_button_led_controller_core_tb.sv -----
// ----------------------------------------------------------------------------
// power_mode_button_led_controller_core_tb
// Drives task ticks and register writes into the power mode controller and
// hands the verdict to the result checker that sits beside it.
// ----------------------------------------------------------------------------
module power_mode_button_led_controller_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pmblc_pkg::*;

  // Index with no register behind it; the block must drop the write
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Watchdog: far beyond the slowest correct run
  localparam int unsigned RUN_LIMIT_NS = 3_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  int open_results;
  int fail_count;

  // Stimulus bookkeeping
  int   ticks_sent = 0;
  logic gaps_on = 1'b1;
  int   hold_cur = 100;
  int   idle_cur = 20000;

  // Slowly changing surroundings of the device between ticks
  logic       env_pin = 1'b1;
  logic [2:0] env_bits = 3'd0;
  logic       env_link = 1'b0;
  logic       env_advstop = 1'b0;

  power_mode_button_led_controller_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mode_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .open_results (open_results),
    .fail_count   (fail_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random while gaps are on, drain every cycle otherwise
  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 19);
  end

  // Pack one tick, button level in bit 0
  function automatic logic [7:0] tick_word(input logic btn, input logic pin,
                                           input logic [2:0] bits, input logic link,
                                           input logic advstop);
    return {1'b0, advstop, link, bits, pin, btn};
  endfunction

  // Any charger code except the fully charged one
  function automatic logic [2:0] plain_bits();
    logic [2:0] b;
    b = 3'($urandom_range(0, 6));
    if (b == CHARGER_FULL_CODE) b = 3'd7;
    return b;
  endfunction

  // Offer one tick, with random idle cycles ahead of it, and hold it until the
  // transfer; tvalid stays high so back-to-back ticks need no extra edge.
  task automatic send_raw(input logic [7:0] d);
    while (gaps_on && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  task automatic send_tick(input logic btn);
    send_raw(tick_word(btn, env_pin, env_bits, env_link, env_advstop));
  endtask

  // Drop tvalid and wait until every result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers while the block is idle, plus one write to the
  // unused index that must change nothing
  task automatic load_regs(input logic [19:0] idle_v, input logic [19:0] hold_v,
                           input logic [19:0] conn_v);
    settle();
    cfg_put(CFG_IDLE_TIMEOUT, idle_v);
    cfg_put(CFG_UNUSED, 20'($urandom));
    cfg_put(CFG_HOLD, hold_v);
    cfg_put(CFG_CONN_LED, conn_v);
    cfg_valid <= 1'b0;
    idle_cur = idle_v;
    hold_cur = hold_v[15:0];
  endtask

  // Mostly well-formed button and charger sequences, some noise
  task automatic run_random(input int n);
    int first;
    int lim;
    first = ticks_sent;
    while (ticks_sent - first < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // short press
          repeat ($urandom_range(1, 2)) send_tick(1'b1);
          lim = (hold_cur > 13) ? 12 : ((hold_cur > 1) ? hold_cur - 1 : 1);
          repeat ($urandom_range(1, lim)) send_tick(1'b0);
          send_tick(1'b1);
        end
        4: begin
          // long hold, only where the hold length is reachable
          if (hold_cur <= 20) begin
            repeat (hold_cur + $urandom_range(1, 3)) send_tick(1'b0);
          end else begin
            repeat ($urandom_range(1, 12)) send_tick(1'b0);
          end
          send_tick(1'b1);
        end
        5: begin
          // charging episode, sometimes reaching full charge
          env_pin = 1'b0;
          repeat ($urandom_range(1, 4)) send_tick(1'b1);
          if ($urandom_range(1)) env_bits = CHARGER_FULL_CODE;
          repeat ($urandom_range(1, 4)) send_tick(1'b1);
          env_pin  = 1'b1;
          env_bits = plain_bits();
          repeat ($urandom_range(1, 3)) send_tick(1'b1);
        end
        6: begin
          // connection with random button activity
          env_link = 1'b1;
          repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(1)));
          env_link = 1'b0;
          send_tick(1'b1);
        end
        7: begin
          // sit idle long enough for the timeout where it is short
          repeat ((idle_cur <= 40) ? idle_cur + 2 : $urandom_range(1, 10)) send_tick(1'b1);
        end
        8: begin
          repeat ($urandom_range(1, 4)) send_raw(8'($urandom_range(0, 127)));
        end
        default: begin
          env_advstop = 1'($urandom_range(1));
          env_bits    = plain_bits();
          send_tick(1'b1);
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: press ignored until first release, all-ones tick connects,
    // all-zero tick starts charging, then full, stop with advertising restart
    send_raw(tick_word(1'b0, 1'b1, 3'd0, 1'b0, 1'b0));
    send_raw(8'h7F);
    send_raw(8'h00);
    send_raw(tick_word(1'b1, 1'b0, 3'd0, 1'b0, 1'b0));
    send_raw(tick_word(1'b1, 1'b0, CHARGER_FULL_CODE, 1'b0, 1'b0));
    send_raw(tick_word(1'b1, 1'b1, 3'd5, 1'b0, 1'b1));
    send_raw(tick_word(1'b1, 1'b1, 3'd5, 1'b0, 1'b1));
    // Four short presses: preset 1, 2, 3, then stimuli off
    repeat (4) begin
      send_raw(tick_word(1'b0, 1'b1, 3'd1, 1'b0, 1'b0));
      send_raw(tick_word(1'b1, 1'b1, 3'd2, 1'b0, 1'b0));
    end

    // Short settings; junk above bit 15 of the hold write must be dropped
    load_regs(20'd3, 20'hA0002, 20'd2);
    // Long hold arms shutdown, release powers down, next tick hibernates
    repeat (2) send_raw(tick_word(1'b0, 1'b1, 3'd0, 1'b0, 1'b0));
    repeat (2) send_raw(tick_word(1'b1, 1'b1, 3'd0, 1'b0, 1'b0));
    // Idle timeout runs out from advertising
    repeat (4) send_raw(tick_word(1'b1, 1'b1, 3'd0, 1'b0, 1'b0));
    // Connected LED lit for two ticks, then off for good
    repeat (3) send_raw(tick_word(1'b1, 1'b1, 3'd0, 1'b1, 1'b0));
    send_raw(tick_word(1'b1, 1'b1, 3'd0, 1'b0, 1'b0));

    // One stretch with no idling on either side
    load_regs(20'd8, 20'd3, 20'd4);
    gaps_on = 1'b0;
    run_random(120);
    gaps_on = 1'b1;

    // Extremes: zero registers, then the largest values, then ones
    load_regs(20'd0, 20'd0, 20'd0);
    run_random(60);
    load_regs(20'hFFFFF, 20'd65535, 20'd65535);
    run_random(40);
    load_regs(20'd1, 20'd1, 20'd1);
    run_random(60);

    repeat (6) begin
      load_regs(20'($urandom_range(2, 60)), 20'($urandom_range(1, 8)),
                20'($urandom_range(1, 30)));
      run_random(70);
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pmblc_pkg.sv
rtl/core/pmblc_button.sv
rtl/core/pmblc_fsm.sv
rtl/core/pmblc_led.sv
rtl/core/power_mode_button_led_controller_core.sv
bench/mode_result_checker.sv
bench/power_mode_button_led_controller_core_tb.sv
